// ----- rtl/core/vfc_pkg.sv -----
package vfc_pkg;

   localparam int unsigned CordicSteps = 24;
   localparam int unsigned CordicW     = 34;
   localparam int unsigned ZW          = 32;
   localparam int unsigned CoordW      = 32;
   localparam int unsigned GeoW        = 24;
   localparam int unsigned ProdW       = CordicW + GeoW;
   localparam int unsigned CsrIdxW     = 3;

   // Fraction bits of every coordinate and angle bits of the heading field.
   localparam int unsigned FracBits    = 16;
   localparam int unsigned AngleBits   = 16;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_CENTER_OFFSET = 3'd0,
      CSR_LATERAL_MARGIN = 3'd1,
      CSR_LONG_MARGIN = 3'd2,
      CSR_BODY_LENGTH = 3'd3,
      CSR_BODY_WIDTH = 3'd4
   } csr_index_type;

   // Start value of the rotation, gain-corrected unity in Q30.
   localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;

   // Arctangent of 2^-i, with a full turn as 2^32.
   function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      unique case (idx)
         5'd0: v = 32'sd536870912;
         5'd1: v = 32'sd316933406;
         5'd2: v = 32'sd167458907;
         5'd3: v = 32'sd85004756;
         5'd4: v = 32'sd42667331;
         5'd5: v = 32'sd21354465;
         5'd6: v = 32'sd10679838;
         5'd7: v = 32'sd5340245;
         5'd8: v = 32'sd2670163;
         5'd9: v = 32'sd1335087;
         5'd10: v = 32'sd667544;
         5'd11: v = 32'sd333772;
         5'd12: v = 32'sd166886;
         5'd13: v = 32'sd83443;
         5'd14: v = 32'sd41722;
         5'd15: v = 32'sd20861;
         5'd16: v = 32'sd10430;
         5'd17: v = 32'sd5215;
         5'd18: v = 32'sd2608;
         5'd19: v = 32'sd1304;
         5'd20: v = 32'sd652;
         5'd21: v = 32'sd326;
         5'd22: v = 32'sd163;
         5'd23: v = 32'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Pipeline stage valid and stall control.
   typedef struct packed {
      logic advance;
      logic in_valid;
   } stage_ctrl_type;

   // Sine and cosine in Q30 together with the pose.
   typedef struct packed {
      logic signed [CordicW-1:0] cos_val;
      logic signed [CordicW-1:0] sin_val;
      logic signed [CoordW-1:0] pose_x;
      logic signed [CoordW-1:0] pose_y;
   } trig_type;

endpackage

// ----- rtl/core/vfc_cordic.sv -----
// Pipelined rotation CORDIC: one step per register stage, plus an entry stage
// and a quadrant fold-out stage. It stalls as a whole when ctrl.advance is low.
module vfc_cordic
   import vfc_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  stage_ctrl_type            ctrl,
   input  logic [ANGLE_BITS-1:0]     angle,
   input  logic signed [CoordW-1:0]  pose_x,
   input  logic signed [CoordW-1:0]  pose_y,
   output logic                      out_valid,
   output trig_type                  out_trig
);

   localparam int unsigned NStage = CordicSteps + 1;

   logic signed [CordicW-1:0] x_ff [NStage];
   logic signed [CordicW-1:0] y_ff [NStage];
   logic signed [ZW-1:0]      z_ff [NStage];
   logic [1:0]                q_ff [NStage];
   logic signed [CoordW-1:0]  px_ff [NStage];
   logic signed [CoordW-1:0]  py_ff [NStage];
   logic [NStage-1:0]         v_ff;
   logic [ZW-1:0]             turn_in;
   trig_type                  trig_ff;
   logic                      tv_ff;

   // The angle is scaled up to a 32-bit turn.
   assign turn_in = {angle, {(ZW - ANGLE_BITS){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         tv_ff <= 1'b0;
      end else if (ctrl.advance) begin
         v_ff <= {v_ff[NStage-2:0], ctrl.in_valid};
         tv_ff <= v_ff[NStage-1];
      end
   end

   // Entry stage: quadrant split.
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         x_ff[0] <= CordicX0;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({2'b00, turn_in[ZW-3:0]});
         q_ff[0] <= turn_in[ZW-1:ZW-2];
         px_ff[0] <= pose_x;
         py_ff[0] <= pose_y;
      end
   end

   // One micro-rotation per stage; arithmetic shifts are floor shifts.
   for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turn(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turn(5'(i));
            end
            q_ff[i+1] <= q_ff[i];
            px_ff[i+1] <= px_ff[i];
            py_ff[i+1] <= py_ff[i];
         end
      end
   end

   // Quadrant fold-out.
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         unique case (q_ff[NStage-1])
            2'd0: begin
               trig_ff.cos_val <= x_ff[NStage-1];
               trig_ff.sin_val <= y_ff[NStage-1];
            end
            2'd1: begin
               trig_ff.cos_val <= -y_ff[NStage-1];
               trig_ff.sin_val <= x_ff[NStage-1];
            end
            2'd2: begin
               trig_ff.cos_val <= -x_ff[NStage-1];
               trig_ff.sin_val <= -y_ff[NStage-1];
            end
            default: begin
               trig_ff.cos_val <= y_ff[NStage-1];
               trig_ff.sin_val <= -x_ff[NStage-1];
            end
         endcase
         trig_ff.pose_x <= px_ff[NStage-1];
         trig_ff.pose_y <= py_ff[NStage-1];
      end
   end

   assign out_valid = tv_ff;
   assign out_trig = trig_ff;

endmodule

// ----- rtl/core/vehicle_footprint_corners_core.sv -----
// Footprint corners: one pose beat in, one beat of four corners out, one beat
// per cycle sustained while the result side takes beats. The path is a
// 24-stage pipelined CORDIC with entry and quadrant stages, a product stage
// of six 34x24 multipliers, a sum stage and the output register, which is
// fed by the saturating add. The whole pipeline holds when the result side
// stalls, so req_tready follows rsp_tready whenever the output register is
// occupied. Configuration beats are taken at any time but only while the
// block is idle do they give consistent results.
module vehicle_footprint_corners_core
   import vfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pose_x [31:0], pose_y [63:32], heading [79:64]
   input  logic [79:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // front_right_x, front_right_y, front_left_x, front_left_y,
   // rear_left_x, rear_left_y, rear_right_x, rear_right_y; 32 bits each
   output logic [255:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [31:0]   csr_data
);

   // Q30 trig times half-unit distances: rounding at bit 31 for any fraction width.
   localparam int unsigned RndBit = 30;

   logic signed [21:0] center_offset_ff;
   logic signed [20:0] lateral_margin_ff;
   logic signed [20:0] long_margin_ff;
   logic [20:0]        body_length_ff;
   logic [19:0]        body_width_ff;

   logic signed [GeoW-1:0] f2;
   logic signed [GeoW-1:0] r2;
   logic signed [GeoW-1:0] s2;

   stage_ctrl_type ctrl;
   logic           trig_valid;
   trig_type       trig;

   logic signed [ProdW-1:0] cf_ff, sf_ff, cr_ff, sr_ff, ss_ff, cs_ff;
   logic signed [CoordW-1:0] px_p_ff, py_p_ff, px_s_ff, py_s_ff;
   logic signed [ProdW:0]   sum_ff [8];
   logic [1:0]              pv_ff;
   logic                    out_valid_ff;
   logic [255:0]            out_data_ff;
   logic [255:0]            out_data_in;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         center_offset_ff <= '0;
         lateral_margin_ff <= '0;
         long_margin_ff <= '0;
         body_length_ff <= '0;
         body_width_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_OFFSET: center_offset_ff <= csr_data[21:0];
            CSR_LATERAL_MARGIN: lateral_margin_ff <= csr_data[20:0];
            CSR_LONG_MARGIN: long_margin_ff <= csr_data[20:0];
            CSR_BODY_LENGTH: body_length_ff <= csr_data[20:0];
            CSR_BODY_WIDTH: body_width_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // Edge distances in half units; static while the block runs.
   assign f2 = (GeoW'(center_offset_ff) <<< 1) + $signed(GeoW'(body_length_ff))
               + (GeoW'(long_margin_ff) <<< 1);
   assign r2 = (GeoW'(center_offset_ff) <<< 1) - $signed(GeoW'(body_length_ff));
   assign s2 = $signed(GeoW'(body_width_ff)) + (GeoW'(lateral_margin_ff) <<< 1);

   // The whole pipeline moves when the output register can take a beat.
   assign ctrl.advance = !out_valid_ff || rsp_tready;
   assign ctrl.in_valid = req_tvalid;
   assign req_tready = ctrl.advance;

   vfc_cordic #(
      .ANGLE_BITS(AngleBits)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .ctrl(ctrl),
      .angle(req_tdata[64 +: AngleBits]),
      .pose_x($signed(req_tdata[31:0])),
      .pose_y($signed(req_tdata[63:32])),
      .out_valid(trig_valid),
      .out_trig(trig)
   );

   // Product stage.
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         cf_ff <= trig.cos_val * f2;
         sf_ff <= trig.sin_val * f2;
         cr_ff <= trig.cos_val * r2;
         sr_ff <= trig.sin_val * r2;
         ss_ff <= trig.sin_val * s2;
         cs_ff <= trig.cos_val * s2;
         px_p_ff <= trig.pose_x;
         py_p_ff <= trig.pose_y;
      end
   end

   // Sum stage, rounding constant included.
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         sum_ff[0] <= (ProdW+1)'(cf_ff) + ss_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[1] <= (ProdW+1)'(sf_ff) - cs_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[2] <= (ProdW+1)'(cf_ff) - ss_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[3] <= (ProdW+1)'(sf_ff) + cs_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[4] <= (ProdW+1)'(cr_ff) - ss_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[5] <= (ProdW+1)'(sr_ff) + cs_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[6] <= (ProdW+1)'(cr_ff) + ss_ff + ((ProdW+1)'(1) <<< RndBit);
         sum_ff[7] <= (ProdW+1)'(sr_ff) - cs_ff + ((ProdW+1)'(1) <<< RndBit);
         px_s_ff <= px_p_ff;
         py_s_ff <= py_p_ff;
      end
   end

   // Offset plus pose, saturated to 32 bits.
   always_comb begin
      logic signed [ProdW-31:0] offv;
      logic signed [CoordW+1:0] tot;
      out_data_in = '0;
      for (int k = 0; k < 8; k++) begin
         offv = sum_ff[k][ProdW:31];
         tot = (CoordW+2)'(offv) + ((k % 2 == 0) ? (CoordW+2)'(px_s_ff)
                                                 : (CoordW+2)'(py_s_ff));
         if (tot > 34'sh0_7fff_ffff) begin
            out_data_in[k*32 +: 32] = 32'h7fffffff;
         end else if (tot < -34'sh0_8000_0000) begin
            out_data_in[k*32 +: 32] = 32'h80000000;
         end else begin
            out_data_in[k*32 +: 32] = tot[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         pv_ff <= {pv_ff[0], trig_valid};
         out_valid_ff <= pv_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   // A held result beat keeps its data until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // The input side stalls exactly when the output register is full and held.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready out of step with output stall");

   // Pipeline valids only shift on an advance.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      !ctrl.advance |=> $stable(pv_ff))
      else $error("pipeline valid moved during a stall");

endmodule
